FILE: rtl/core/chunk_residency_request_table_core_macros.svh
// assertion macros shared by the chunk residency request table rtl
`ifndef CHUNK_RESIDENCY_REQUEST_TABLE_CORE_MACROS_SVH
`define CHUNK_RESIDENCY_REQUEST_TABLE_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, disabled during reset
`define CRRT_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("crrt assertion failed");

// next-cycle implication, disabled during reset
`define CRRT_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("crrt assertion failed");

`else

`define CRRT_ASSERT_IMP(name, clk, rst_n, ante, cons)
`define CRRT_ASSERT_NXT(name, clk, rst_n, ante, cons)

`endif

`endif

FILE: rtl/core/crrt_pkg.sv
// types, codes and defaults of the chunk residency request table
package crrt_pkg;

    // default sizing of the tables
    localparam int RESIDENT_DEPTH_DEF = 64;
    localparam int PENDING_DEPTH_DEF  = 16;
    localparam int COORD_BITS_DEF     = 16;

    // fixed port widths
    localparam int COORD_W = 16;
    localparam int SLOT_W  = 6;
    localparam int OP_W    = 2;

    // operation codes
    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
    localparam logic [OP_W-1:0] OP_ORDER  = 2'd1;
    localparam logic [OP_W-1:0] OP_RETIRE = 2'd2;

    // one result transaction
    typedef struct packed {
        logic                      hit;
        logic [SLOT_W-1:0]         slot_index;
        logic                      newly_ordered;
        logic                      already_pending;
        logic                      retired;
        logic                      full_flag;
        logic signed [COORD_W-1:0] retired_x;
        logic signed [COORD_W-1:0] retired_y;
        logic signed [COORD_W-1:0] retired_z;
    } t_result;

endpackage

FILE: rtl/core/crrt_ram.sv
// generic single write port ram with registered read
module crrt_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/chunk_residency_request_table_core.sv
// top level: resident and pending chunk tables with scan and retire control
// A lookup scans the resident table one entry per cycle over its read port;
// a miss that orders then also scans the pending table. One transaction is
// worked at a time; the output register lets the next be accepted while a
// result waits. Reset clears both counts; table contents are left unknown and
// are never read before being written, so no clearing pass.
`include "chunk_residency_request_table_core_macros.svh"

module chunk_residency_request_table_core
    import crrt_pkg::*;
#(
    parameter int RESIDENT_DEPTH = RESIDENT_DEPTH_DEF,
    parameter int PENDING_DEPTH  = PENDING_DEPTH_DEF,
    parameter int COORD_BITS     = COORD_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // input channel
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic [OP_W-1:0]           i_operation,
    input  logic signed [COORD_W-1:0] i_coord_x,
    input  logic signed [COORD_W-1:0] i_coord_y,
    input  logic signed [COORD_W-1:0] i_coord_z,
    // output channel
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic                      o_hit,
    output logic [SLOT_W-1:0]         o_slot_index,
    output logic                      o_newly_ordered,
    output logic                      o_already_pending,
    output logic                      o_retired,
    output logic                      o_full_flag,
    output logic signed [COORD_W-1:0] o_retired_x,
    output logic signed [COORD_W-1:0] o_retired_y,
    output logic signed [COORD_W-1:0] o_retired_z
);

    localparam int KEY_W  = 3 * COORD_BITS;
    localparam int RIDX_W = (RESIDENT_DEPTH > 1) ? $clog2(RESIDENT_DEPTH) : 1;
    localparam int RCNT_W = $clog2(RESIDENT_DEPTH + 1);
    localparam int PIDX_W = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
    localparam int PCNT_W = $clog2(PENDING_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RSCAN,
        S_PSCAN,
        S_PREAD,
        S_OUT
    } t_state;

    // coordinate wrap into table width and back
    function automatic logic [COORD_BITS-1:0] f_take(input logic signed [COORD_W-1:0] v);
        return COORD_BITS'(v);
    endfunction

    function automatic logic signed [COORD_W-1:0] f_give(input logic [COORD_BITS-1:0] c);
        return COORD_W'($signed(c));
    endfunction

    t_state              r_state, n_state;
    logic [RCNT_W-1:0]   r_rcnt, n_rcnt;
    logic [PCNT_W-1:0]   r_pcnt, n_pcnt;
    logic [RCNT_W-1:0]   r_rptr, n_rptr;
    logic [PCNT_W-1:0]   r_pptr, n_pptr;
    logic                r_rd_vld, n_rd_vld;
    logic [RIDX_W-1:0]   r_rd_idx, n_rd_idx;
    logic [OP_W-1:0]     r_op, n_op;
    logic [KEY_W-1:0]    r_key, n_key;
    t_result             r_res, n_res;
    t_result             r_out, n_out;
    logic                r_o_valid, n_o_valid;

    logic                res_we;
    logic [RIDX_W-1:0]   res_waddr;
    logic [KEY_W-1:0]    res_wdata;
    logic [KEY_W-1:0]    res_rdata;
    logic                pnd_we;
    logic [PIDX_W-1:0]   pnd_raddr;
    logic [KEY_W-1:0]    pnd_rdata;
    logic [PCNT_W-1:0]   pcnt_dec;
    logic                rissue;
    logic                pissue;

    // resident table
    crrt_ram #(
        .WIDTH (KEY_W),
        .DEPTH (RESIDENT_DEPTH)
    ) u_res_ram (
        .i_clk   (i_clk),
        .i_we    (res_we),
        .i_waddr (res_waddr),
        .i_wdata (res_wdata),
        .i_raddr (r_rptr[RIDX_W-1:0]),
        .o_rdata (res_rdata)
    );

    // pending table
    crrt_ram #(
        .WIDTH (KEY_W),
        .DEPTH (PENDING_DEPTH)
    ) u_pnd_ram (
        .i_clk   (i_clk),
        .i_we    (pnd_we),
        .i_waddr (r_pcnt[PIDX_W-1:0]),
        .i_wdata (r_key),
        .i_raddr (pnd_raddr),
        .o_rdata (pnd_rdata)
    );

    // pending read: newest entry while idle (for retire), scan pointer otherwise
    assign pcnt_dec  = r_pcnt - PCNT_W'(1);
    assign pnd_raddr = (r_state == S_IDLE) ? pcnt_dec[PIDX_W-1:0] : r_pptr[PIDX_W-1:0];
    assign rissue    = (r_rptr < r_rcnt);
    assign pissue    = (r_pptr < r_pcnt);

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_rcnt    = r_rcnt;
        n_pcnt    = r_pcnt;
        n_rptr    = r_rptr;
        n_pptr    = r_pptr;
        n_rd_vld  = r_rd_vld;
        n_rd_idx  = r_rd_idx;
        n_op      = r_op;
        n_key     = r_key;
        n_res     = r_res;
        n_out     = r_out;
        n_o_valid = r_o_valid && i_stall;
        res_we    = 1'b0;
        res_waddr = r_rcnt[RIDX_W-1:0];
        res_wdata = pnd_rdata;
        pnd_we    = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_op     = i_operation;
                    n_key    = {f_take(i_coord_x), f_take(i_coord_y), f_take(i_coord_z)};
                    n_rptr   = '0;
                    n_pptr   = '0;
                    n_rd_vld = 1'b0;
                    n_res    = '0;
                    unique case (i_operation)
                        OP_LOOKUP, OP_ORDER: begin
                            n_state = S_RSCAN;
                        end
                        OP_RETIRE: begin
                            priority if (r_pcnt == '0) begin
                                n_state = S_OUT;
                            end else if (r_rcnt == RCNT_W'(RESIDENT_DEPTH)) begin
                                n_res.full_flag = 1'b1;
                                n_state         = S_OUT;
                            end else begin
                                n_state = S_PREAD;
                            end
                        end
                        default: begin
                            n_state = S_OUT;
                        end
                    endcase
                end
            end

            // one resident entry issued per cycle, compared in the next cycle
            S_RSCAN: begin
                n_rd_vld = rissue;
                n_rd_idx = r_rptr[RIDX_W-1:0];
                if (rissue) begin
                    n_rptr = r_rptr + RCNT_W'(1);
                end
                priority if (r_rd_vld && (res_rdata == r_key)) begin
                    n_res.hit        = 1'b1;
                    n_res.slot_index = SLOT_W'(r_rd_idx);
                    n_state          = S_OUT;
                end else if (!rissue) begin
                    if (r_op == OP_LOOKUP) begin
                        n_state = S_OUT;
                    end else begin
                        n_rd_vld = 1'b0;
                        n_state  = S_PSCAN;
                    end
                end
            end

            // pending scan, then append on a clean miss unless the pending table is full
            S_PSCAN: begin
                n_rd_vld = pissue;
                if (pissue) begin
                    n_pptr = r_pptr + PCNT_W'(1);
                end
                priority if (r_rd_vld && (pnd_rdata == r_key)) begin
                    n_res.already_pending = 1'b1;
                    n_state               = S_OUT;
                end else if (!pissue) begin
                    if (r_pcnt < PCNT_W'(PENDING_DEPTH)) begin
                        pnd_we              = 1'b1;
                        n_pcnt              = r_pcnt + PCNT_W'(1);
                        n_res.newly_ordered = 1'b1;
                    end else begin
                        n_res.full_flag = 1'b1;
                    end
                    n_state = S_OUT;
                end
            end

            // newest pending entry is on the read port: move it to resident
            S_PREAD: begin
                res_we           = 1'b1;
                n_rcnt           = r_rcnt + RCNT_W'(1);
                n_pcnt           = pcnt_dec;
                n_res.retired    = 1'b1;
                n_res.slot_index = SLOT_W'(r_rcnt);
                n_res.retired_x  = f_give(pnd_rdata[3*COORD_BITS-1:2*COORD_BITS]);
                n_res.retired_y  = f_give(pnd_rdata[2*COORD_BITS-1:COORD_BITS]);
                n_res.retired_z  = f_give(pnd_rdata[COORD_BITS-1:0]);
                n_state          = S_OUT;
            end

            // hand the result to the output register once it is free
            S_OUT: begin
                if (!r_o_valid || !i_stall) begin
                    n_o_valid = 1'b1;
                    n_out     = r_res;
                    n_state   = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_rcnt    <= '0;
            r_pcnt    <= '0;
            r_rd_vld  <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rcnt    <= n_rcnt;
            r_pcnt    <= n_pcnt;
            r_rd_vld  <= n_rd_vld;
            r_o_valid <= n_o_valid;
        end
        r_rptr   <= n_rptr;
        r_pptr   <= n_pptr;
        r_rd_idx <= n_rd_idx;
        r_op     <= n_op;
        r_key    <= n_key;
        r_res    <= n_res;
        r_out    <= n_out;
    end

    // ports
    assign o_stall           = (r_state != S_IDLE);
    assign o_valid           = r_o_valid;
    assign o_hit             = r_out.hit;
    assign o_slot_index      = r_out.slot_index;
    assign o_newly_ordered   = r_out.newly_ordered;
    assign o_already_pending = r_out.already_pending;
    assign o_retired         = r_out.retired;
    assign o_full_flag       = r_out.full_flag;
    assign o_retired_x       = r_out.retired_x;
    assign o_retired_y       = r_out.retired_y;
    assign o_retired_z       = r_out.retired_z;

    // checks
    `CRRT_ASSERT_IMP(a_rcnt_bound, i_clk, i_rst_n, 1'b1, r_rcnt <= RCNT_W'(RESIDENT_DEPTH))
    `CRRT_ASSERT_IMP(a_pcnt_bound, i_clk, i_rst_n, 1'b1, r_pcnt <= PCNT_W'(PENDING_DEPTH))
    `CRRT_ASSERT_IMP(a_one_outcome, i_clk, i_rst_n, o_valid, $countones({o_hit, o_newly_ordered, o_already_pending, o_retired, o_full_flag}) <= 1)
    `CRRT_ASSERT_NXT(a_retire_moves, i_clk, i_rst_n, r_state == S_PREAD, (r_pcnt == $past(r_pcnt) - PCNT_W'(1)) && (r_rcnt == $past(r_rcnt) + RCNT_W'(1)))
    `CRRT_ASSERT_NXT(a_result_held, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(r_out))

endmodule
